@@ src/tcc_pkg.sv @@
// Package for the text console character engine.
// Holds the queue entry and configuration types, character and register codes,
// and the geometry clamps. It depends on nothing else.
package tcc_pkg;

  localparam int CNT_W = 14;

  localparam logic [2:0] K_NOP   = 3'd0;
  localparam logic [2:0] K_PRINT = 3'd1;
  localparam logic [2:0] K_LF    = 3'd2;
  localparam logic [2:0] K_CR    = 3'd3;
  localparam logic [2:0] K_BS    = 3'd4;
  localparam logic [2:0] K_DEL   = 3'd5;
  localparam logic [2:0] K_TAB   = 3'd6;
  localparam logic [2:0] K_READ  = 3'd7;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_LINES = 2'd1;
  localparam logic [1:0] REG_ATTR  = 2'd2;
  localparam logic [1:0] REG_ERASE = 2'd3;

  localparam logic [7:0]  COLS_MIN    = 8'd2;
  localparam logic [7:0]  COLS_MAX    = 8'd160;
  localparam logic [6:0]  LINES_MIN   = 7'd2;
  localparam logic [6:0]  LINES_MAX   = 7'd100;
  localparam logic [7:0]  COLS_RESET  = 8'd80;
  localparam logic [6:0]  LINES_RESET = 7'd25;
  localparam logic [7:0]  ATTR_RESET  = 8'h07;
  localparam logic [15:0] ERASE_RESET = 16'h0000;
  localparam logic [14:0] END_RESET   = 15'd2000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [13:0] read_addr;
  } tcc_entry_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } tcc_cfg_t;

  function automatic logic [7:0] clamp_cols(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v < COLS_MIN) r = COLS_MIN;
    if (v > COLS_MAX) r = COLS_MAX;
    return r;
  endfunction

  function automatic logic [6:0] clamp_lines(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v < LINES_MIN) r = LINES_MIN;
    if (v > LINES_MAX) r = LINES_MAX;
    return r;
  endfunction

endpackage

@@ src/tcc_front.sv @@
// Front end of the text console character engine: accepts beats, classifies them
// and holds them in a two-entry queue for the back end. Depends on tcc_pkg.
module tcc_front import tcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_char_code,
  input  logic [13:0] in_read_addr,
  input  logic        pop,
  output logic        q_valid,
  output tcc_entry_t  q_entry
);

  tcc_entry_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  tcc_entry_t entry_in;

  always_comb begin
    entry_in.char_code = in_char_code;
    entry_in.read_addr = in_read_addr;
    if (in_action) begin
      entry_in.kind = K_READ;
    end else if (in_char_code >= CH_SPACE && in_char_code < CH_DEL) begin
      entry_in.kind = K_PRINT;
    end else begin
      case (in_char_code)
        CH_LF, CH_VT, CH_FF: entry_in.kind = K_LF;
        CH_CR:               entry_in.kind = K_CR;
        CH_BS:               entry_in.kind = K_BS;
        CH_DEL:              entry_in.kind = K_DEL;
        CH_TAB:              entry_in.kind = K_TAB;
        default:             entry_in.kind = K_NOP;
      endcase
    end
  end

  assign busy    = (count_r == 2'd2);
  assign push    = start & ~busy;
  assign q_valid = (count_r != 2'd0);
  assign q_entry = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/tcc_back.sv @@
// Back end of the text console character engine: cursor and scroll sequencer,
// video memory, configuration registers and the result register.
// Depends on tcc_pkg; fed by tcc_front.
module tcc_back import tcc_pkg::*; #(
  parameter int MEM_WORDS = 16384,
  parameter int TAB_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  tcc_entry_t  q_entry,
  output logic        pop,
  input  tcc_cfg_t    cfg,
  output logic        out_valid,
  output logic [13:0] out_origin_offset,
  output logic [13:0] out_cursor_offset,
  output logic [7:0]  out_cursor_col,
  output logic [6:0]  out_cursor_row,
  output logic [15:0] out_read_word
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int PW = (AW > 14) ? AW : 14;
  localparam int EW = (AW + 1 > 15) ? AW + 1 : 15;
  localparam logic [EW-1:0] MEM_LIMIT = EW'(MEM_WORDS);
  localparam int unsigned TAB_RECIP = (65536 + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam logic [7:0] TAB_STEP = 8'(TAB_WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAB  = 3'd1;
  localparam logic [2:0] S_LF   = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;
  localparam logic [2:0] S_RD   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [7:0]       col_r, col_nxt;
  logic [6:0]       row_r, row_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [EW-1:0]    origin_r, origin_nxt;
  logic [EW-1:0]    end_r, end_nxt;
  logic [13:0]      rowoff_r, rowoff_nxt;
  logic [7:0]       cols_r, cols_nxt;
  logic [6:0]       lines_r, lines_nxt;
  logic [7:0]       attr_r, attr_nxt;
  logic [15:0]      erase_r, erase_nxt;
  logic             put_r, put_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] wcnt_r, wcnt_nxt;
  logic             wpend_r, wpend_nxt;
  logic [EW-1:0]    clr_base_r, clr_base_nxt;
  logic [7:0]       tabq_r;
  logic [23:0]      tab_prod;
  logic [7:0]       tab_rem, tab_col;
  logic [15:0]      rdata_r;
  logic [15:0]      vram [MEM_WORDS];

  logic             mem_we;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [15:0]      mem_wd;
  logic             fin;
  logic [15:0]      word;
  logic [7:0]       home_cols;
  logic [6:0]       home_lines;
  logic [14:0]      home_end;

  logic             out_valid_r;
  logic [13:0]      out_origin_r, out_cursor_r;
  logic [7:0]       out_col_r;
  logic [6:0]       out_row_r;
  logic [15:0]      out_word_r;

  assign tab_prod = col_r * 16'(TAB_RECIP);
  assign tab_rem  = col_r - 8'(tabq_r * TAB_WIDTH);
  assign tab_col  = col_r + TAB_STEP - tab_rem;

  assign home_cols  = (cfg.index == REG_COLS) ? clamp_cols(cfg.data[7:0]) : cols_r;
  assign home_lines = (cfg.index == REG_LINES) ? clamp_lines(cfg.data[6:0]) : lines_r;
  assign home_end   = 15'(home_lines) * 15'(home_cols);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pos_nxt      = pos_r;
    origin_nxt   = origin_r;
    end_nxt      = end_r;
    rowoff_nxt   = rowoff_r;
    cols_nxt     = cols_r;
    lines_nxt    = lines_r;
    attr_nxt     = attr_r;
    erase_nxt    = erase_r;
    put_nxt      = put_r;
    char_nxt     = char_r;
    cnt_nxt      = cnt_r;
    wcnt_nxt     = wcnt_r;
    wpend_nxt    = wpend_r;
    clr_base_nxt = clr_base_r;
    mem_we       = 1'b0;
    mem_wa       = pos_r[AW-1:0];
    mem_wd       = erase_r;
    mem_ra       = AW'(q_entry.read_addr);
    pop          = 1'b0;
    fin          = 1'b0;
    word         = 16'd0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_entry.kind)
            K_PRINT: begin
              if (col_r >= cols_r) begin
                col_nxt   = col_r - cols_r;
                pos_nxt   = pos_r - PW'(cols_r);
                put_nxt   = 1'b1;
                char_nxt  = q_entry.char_code;
                state_nxt = S_LF;
              end else begin
                mem_we  = 1'b1;
                mem_wd  = {attr_r, q_entry.char_code};
                col_nxt = col_r + 8'd1;
                pos_nxt = pos_r + PW'(1);
                fin     = 1'b1;
              end
            end
            K_LF: begin
              put_nxt   = 1'b0;
              state_nxt = S_LF;
            end
            K_CR: begin
              pos_nxt = pos_r - PW'(col_r);
              col_nxt = 8'd0;
              fin     = 1'b1;
            end
            K_BS: begin
              if (col_r != 8'd0) begin
                col_nxt = col_r - 8'd1;
                pos_nxt = pos_r - PW'(1);
              end
              fin = 1'b1;
            end
            K_DEL: begin
              if (col_r != 8'd0) begin
                col_nxt = col_r - 8'd1;
                pos_nxt = pos_r - PW'(1);
                mem_we  = 1'b1;
                mem_wa  = pos_nxt[AW-1:0];
              end
              fin = 1'b1;
            end
            K_TAB: begin
              state_nxt = S_TAB;
            end
            K_READ: begin
              state_nxt = S_RD;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_TAB: begin
        if (tab_col > cols_r) begin
          col_nxt   = tab_col - cols_r;
          pos_nxt   = pos_r + PW'(tab_col - col_r) - PW'(cols_r);
          put_nxt   = 1'b0;
          state_nxt = S_LF;
        end else begin
          col_nxt   = tab_col;
          pos_nxt   = pos_r + PW'(tab_col - col_r);
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LF: begin
        if ({1'b0, row_r} + 8'd1 < {1'b0, lines_r}) begin
          row_nxt    = row_r + 7'd1;
          rowoff_nxt = rowoff_r + 14'(cols_r);
          pos_nxt    = pos_r + PW'(cols_r);
          if (put_r) begin
            state_nxt = S_PUT;
          end else begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          origin_nxt = origin_r + EW'(cols_r);
          end_nxt    = end_r + EW'(cols_r);
          pos_nxt    = pos_r + PW'(cols_r);
          cnt_nxt    = '0;
          wpend_nxt  = 1'b0;
          if (end_nxt > MEM_LIMIT) begin
            state_nxt = S_COPY;
          end else begin
            clr_base_nxt = end_r;
            state_nxt    = S_CLR;
          end
        end
      end
      S_COPY: begin
        if (wpend_r) begin
          mem_we = 1'b1;
          mem_wa = AW'(wcnt_r);
          mem_wd = rdata_r;
        end
        if (cnt_r < rowoff_r) begin
          mem_ra    = AW'(origin_r + EW'(cnt_r));
          wpend_nxt = 1'b1;
          wcnt_nxt  = cnt_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          wpend_nxt = 1'b0;
          if (!wpend_r) begin
            end_nxt      = end_r - origin_r;
            pos_nxt      = pos_r - origin_r[PW-1:0];
            origin_nxt   = '0;
            clr_base_nxt = EW'(rowoff_r);
            cnt_nxt      = '0;
            state_nxt    = S_CLR;
          end
        end
      end
      S_CLR: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(clr_base_r + EW'(cnt_r));
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(cols_r) - CNT_W'(1)) begin
          if (put_r) begin
            state_nxt = S_PUT;
          end else begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wd    = {attr_r, char_r};
        col_nxt   = col_r + 8'd1;
        pos_nxt   = pos_r + PW'(1);
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        word      = rdata_r;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin && col_nxt <= cols_r) begin
      pos_nxt = origin_nxt[PW-1:0] + PW'(rowoff_nxt) + PW'(col_nxt);
    end

    if (cfg.valid) begin
      case (cfg.index)
        REG_COLS, REG_LINES: begin
          cols_nxt   = home_cols;
          lines_nxt  = home_lines;
          origin_nxt = '0;
          col_nxt    = 8'd0;
          row_nxt    = 7'd0;
          pos_nxt    = '0;
          rowoff_nxt = 14'd0;
          end_nxt    = EW'(home_end);
        end
        REG_ATTR: begin
          attr_nxt = cfg.data[7:0];
        end
        default: begin
          erase_nxt = cfg.data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vram[mem_wa] <= mem_wd;
    end
    rdata_r <= vram[mem_ra];
  end

  always_ff @(posedge clk) begin
    tabq_r       <= tab_prod[23:16];
    char_r       <= char_nxt;
    wcnt_r       <= wcnt_nxt;
    clr_base_r   <= clr_base_nxt;
    out_origin_r <= origin_nxt[13:0];
    out_cursor_r <= pos_nxt[13:0];
    out_col_r    <= col_nxt;
    out_row_r    <= row_nxt;
    out_word_r   <= word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= 8'd0;
      row_r       <= 7'd0;
      pos_r       <= '0;
      origin_r    <= '0;
      end_r       <= EW'(END_RESET);
      rowoff_r    <= 14'd0;
      cols_r      <= COLS_RESET;
      lines_r     <= LINES_RESET;
      attr_r      <= ATTR_RESET;
      erase_r     <= ERASE_RESET;
      put_r       <= 1'b0;
      cnt_r       <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pos_r       <= pos_nxt;
      origin_r    <= origin_nxt;
      end_r       <= end_nxt;
      rowoff_r    <= rowoff_nxt;
      cols_r      <= cols_nxt;
      lines_r     <= lines_nxt;
      attr_r      <= attr_nxt;
      erase_r     <= erase_nxt;
      put_r       <= put_nxt;
      cnt_r       <= cnt_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= fin;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_origin_offset = out_origin_r;
  assign out_cursor_offset = out_cursor_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_read_word     = out_word_r;

endmodule

@@ src/text_console_char_engine.sv @@
// Top level of the text console character engine.
// Instantiates tcc_front and tcc_back; depends on tcc_pkg.
//
// Usage: a beat is taken on a clock edge with start high and busy low. Action 0
// interprets in_char_code as a console byte, action 1 reads the video word at
// in_read_addr. Every beat yields one result, shown for one cycle with out_valid
// high: origin and cursor offsets (CRT start and cursor values), cursor column
// and row, and the read word (zero for puts). The receiver cannot stall.
// Printable and editing bytes are handled in the idle state; reads, tabs and
// line feeds move on to the read, tab or line-feed state. A wrapping printable
// byte then passes through the line-feed and put states, a wrapping tab through
// the line-feed state too. Throughput: one printable byte per cycle while the
// back end is idle, limited by the single memory write port. A scroll clears one
// row; passing the end of memory also copies the upper line_count - 1 rows back
// to the start. A two-beat queue lets the front keep accepting while the back
// sequences; busy rises when the queue is full. The user must write configuration
// only while idle; the block does not enforce it. cfg_ready is always high, and
// a write to column_count or line_count homes the cursor and origin.
// Reset gives an 80 by 25 screen, attribute 7, erase word 0 and the cursor at
// 0,0; video memory contents are undefined until written.
module text_console_char_engine import tcc_pkg::*; #(
  parameter int MEM_WORDS = 16384,
  parameter int TAB_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_char_code,
  input  logic [13:0] in_read_addr,
  output logic        out_valid,
  output logic [13:0] out_origin_offset,
  output logic [13:0] out_cursor_offset,
  output logic [7:0]  out_cursor_col,
  output logic [6:0]  out_cursor_row,
  output logic [15:0] out_read_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tcc_entry_t q_entry;
  tcc_cfg_t   cfg;
  logic       q_valid;
  logic       pop;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid & cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tcc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_char_code (in_char_code),
    .in_read_addr (in_read_addr),
    .pop          (pop),
    .q_valid      (q_valid),
    .q_entry      (q_entry)
  );

  tcc_back #(
    .MEM_WORDS (MEM_WORDS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_entry           (q_entry),
    .pop               (pop),
    .cfg               (cfg),
    .out_valid         (out_valid),
    .out_origin_offset (out_origin_offset),
    .out_cursor_offset (out_cursor_offset),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_read_word     (out_read_word)
  );

endmodule
